// File: hdl/ssig_pkg.sv
// Package for the spiral strip index generator: widths, the phase type and
// the structs that link the pipeline stages. No dependencies.
`default_nettype none

package ssig_pkg;

   // Field widths.
   localparam int GRID_W  = 9;
   localparam int INDEX_W = 16;
   localparam int RUN_W   = 9;

   // Grid size after reset.
   localparam logic [GRID_W-1:0] GRID_RESET = 9'd16;

   // Phases of the strip walk.
   typedef enum logic [2:0] {
      PH_DONE,
      PH_FIRST,
      PH_SECOND,
      PH_RIGHT,
      PH_DOWN,
      PH_LEFT,
      PH_UP
   } phase_type;

   // One item leaving the input register toward the core.
   typedef struct packed {
      logic valid;
      logic restart;
   } item_type;

   // One result computed by the core.
   typedef struct packed {
      logic               emit;
      logic [INDEX_W-1:0] vertex_index;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/ssig_req_if.sv
// Request channel interface: valid, ready and the restart bit.
// Depends on nothing.
`default_nettype none

interface ssig_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// File: hdl/ssig_rsp_if.sv
// Response channel interface: valid, ready, the vertex index and the last flag.
// Depends on ssig_pkg for the index width.
`default_nettype none

interface ssig_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ssig_pkg::INDEX_W-1:0] vertex_index;
   logic                         last;

   modport source (output valid, output vertex_index, output last, input ready);
   modport sink (input valid, input vertex_index, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/spiral_strip_index_generator.sv
// Top level of the spiral strip index generator: grid size register,
// input stage, walk core and result register. Depends on ssig_pkg and both interfaces.
//
// Usage: each request beat on req_ch advances the strip by one index, or
// restarts it when restart is 1. A beat yields one response beat on rsp_ch
// carrying vertex_index and last, except a non-restart beat after the strip
// has ended, which is consumed and yields nothing. The indices spiral inward
// over a grid_size by grid_size grid, opening with 0 and grid_size.
// grid_size is written through csr_wr_en/csr_wr_data; the user must do so only while
// idle, as the block itself does not enforce it. A request accepted into the input
// register passes through the core into the result register, which offers its
// response beat. Throughput: one beat per cycle while the receiver does not stall,
// with the step arithmetic on held history between the two registers.
// Reset clears both stages, sets grid_size to 16 and leaves the strip ended,
// so nothing is produced until a restart beat arrives.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more request, and req_ch.ready drops after that.
`default_nettype none

module spiral_strip_index_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ssig_req_if.sink                           req_ch,
   ssig_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_wr_en,
   input  wire logic [ssig_pkg::GRID_W-1:0]   csr_wr_data
);

   logic [ssig_pkg::GRID_W-1:0] grid_size_ff, grid_size_in;
   ssig_pkg::item_type          item;
   ssig_pkg::result_type        result;
   logic                        out_free;

   // Grid size register.
   assign grid_size_in = csr_wr_en ? csr_wr_data : grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= ssig_pkg::GRID_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   ssig_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .item     (item)
   );

   ssig_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .grid_size (grid_size_ff),
      .result    (result)
   );

   ssig_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .rsp_ch   (rsp_ch),
      .out_free (out_free)
   );

`ifndef SYNTHESIS
   // A restart beat always produces index 0 without the last flag.
   assert property (@(posedge clock) disable iff (reset)
      (item.valid && item.restart) |=>
         (rsp_ch.valid && (rsp_ch.vertex_index == '0) && !rsp_ch.last))
      else $error("restart beat did not produce index 0");

   // A beat is only passed to the core when the result register has room.
   assert property (@(posedge clock) disable iff (reset)
      result.emit |-> out_free)
      else $error("result produced while result register is full");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

// File: hdl/ssig_in_stage.sv
// Input register of the generator: holds one request beat until the
// output stage can take its result. Depends on ssig_pkg and ssig_req_if.
`default_nettype none

module ssig_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   ssig_req_if.sink               req_ch,
   input  wire logic              out_free,
   output ssig_pkg::item_type     item
);

   logic valid_ff, valid_in;
   logic restart_ff, restart_in;
   logic accept;
   logic advance;

   // The held item moves on whenever the result register has room.
   assign advance      = valid_ff && out_free;
   assign req_ch.ready = !valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in   = valid_ff;
      restart_in = restart_ff;
      if (accept) begin
         valid_in   = 1'b1;
         restart_in = req_ch.restart;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      restart_ff <= restart_in;
   end

   assign item.valid   = advance;
   assign item.restart = restart_ff;

endmodule

`default_nettype wire

// File: hdl/ssig_core.sv
// Walk state of the spiral strip and the index arithmetic for one step.
// Depends on ssig_pkg.
`default_nettype none

module ssig_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ssig_pkg::item_type            item,
   input  wire logic [ssig_pkg::GRID_W-1:0]   grid_size,
   output ssig_pkg::result_type               result
);

   localparam int IndexW = ssig_pkg::INDEX_W;
   localparam int GridW  = ssig_pkg::GRID_W;
   localparam int RunW   = ssig_pkg::RUN_W;

   ssig_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [RunW-1:0]     run_count_ff, run_count_in, cur_count;
   logic [RunW-1:0]     run_left_ff, run_left_in, cur_left;
   logic                pair_half_ff, pair_half_in, cur_pair;
   logic [IndexW-1:0]   hist_one_ff, hist_two_ff, hist_three_ff;
   logic [IndexW-1:0]   cur_one, cur_two, cur_three;
   logic [IndexW-1:0]   n_ext, step_val, index_val;
   logic [RunW-1:0]     n_minus, count_dec;
   logic                side_done, emit, last;

   // A restart beat sees the cleared state and begins the list.
   assign cur_phase = item.restart ? ssig_pkg::PH_FIRST : phase_ff;
   assign cur_count = item.restart ? '0 : run_count_ff;
   assign cur_left  = item.restart ? '0 : run_left_ff;
   assign cur_pair  = item.restart ? 1'b0 : pair_half_ff;
   assign cur_one   = item.restart ? '0 : hist_one_ff;
   assign cur_two   = item.restart ? '0 : hist_two_ff;
   assign cur_three = item.restart ? '0 : hist_three_ff;

   // Grid size helpers; the run count saturates at zero.
   assign n_ext     = {{(IndexW - GridW){1'b0}}, grid_size};
   assign n_minus   = (grid_size != '0) ? RunW'(grid_size - 1'b1) : '0;
   assign count_dec = (cur_count != '0) ? cur_count - 1'b1 : cur_count;
   assign side_done = (cur_left == '0);

   // Next phase and run counters.
   always_comb begin
      phase_in     = phase_ff;
      run_count_in = run_count_ff;
      run_left_in  = run_left_ff;
      pair_half_in = pair_half_ff;
      if (item.valid) begin
         phase_in     = cur_phase;
         run_count_in = cur_count;
         run_left_in  = cur_left;
         pair_half_in = cur_pair;
         case (cur_phase)
            ssig_pkg::PH_FIRST: begin
               phase_in = ssig_pkg::PH_SECOND;
            end
            ssig_pkg::PH_SECOND: begin
               run_count_in = n_minus;
               if (n_minus == '0) begin
                  phase_in = ssig_pkg::PH_DONE;
               end else begin
                  phase_in     = ssig_pkg::PH_RIGHT;
                  run_left_in  = n_minus;
                  pair_half_in = 1'b0;
               end
            end
            ssig_pkg::PH_RIGHT, ssig_pkg::PH_DOWN,
            ssig_pkg::PH_LEFT, ssig_pkg::PH_UP: begin
               if (!side_done) begin
                  pair_half_in = !cur_pair;
                  if (cur_pair) begin
                     run_left_in = cur_left - 1'b1;
                  end
               end else begin
                  pair_half_in = 1'b0;
                  if (cur_phase == ssig_pkg::PH_RIGHT) begin
                     run_count_in = count_dec;
                     run_left_in  = count_dec;
                     phase_in     = ssig_pkg::PH_DOWN;
                  end else if (cur_phase == ssig_pkg::PH_DOWN) begin
                     run_left_in = cur_count;
                     phase_in    = ssig_pkg::PH_LEFT;
                  end else if (cur_phase == ssig_pkg::PH_LEFT) begin
                     run_count_in = count_dec;
                     run_left_in  = count_dec;
                     phase_in     = ssig_pkg::PH_UP;
                  end else if (cur_count == '0) begin
                     phase_in = ssig_pkg::PH_DONE;
                  end else begin
                     run_left_in = cur_count;
                     phase_in    = ssig_pkg::PH_RIGHT;
                  end
               end
            end
            default: begin
               phase_in = ssig_pkg::PH_DONE;
            end
         endcase
      end
   end

   // Step added to the second-last index in each side phase.
   always_comb begin
      case (cur_phase)
         ssig_pkg::PH_RIGHT: step_val = IndexW'(1);
         ssig_pkg::PH_DOWN:  step_val = n_ext;
         ssig_pkg::PH_LEFT:  step_val = '1;
         default:            step_val = ~n_ext + 1'b1;
      endcase
   end

   // Emitted index and end-of-strip flag.
   always_comb begin
      emit      = 1'b0;
      index_val = '0;
      last      = 1'b0;
      case (cur_phase)
         ssig_pkg::PH_FIRST: begin
            emit = 1'b1;
         end
         ssig_pkg::PH_SECOND: begin
            emit      = 1'b1;
            index_val = n_ext;
            last      = (n_minus == '0);
         end
         ssig_pkg::PH_RIGHT, ssig_pkg::PH_DOWN,
         ssig_pkg::PH_LEFT, ssig_pkg::PH_UP: begin
            emit      = 1'b1;
            index_val = side_done ? cur_three : cur_two + step_val;
            last      = side_done && (cur_phase == ssig_pkg::PH_UP) && (cur_count == '0);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // State registers; the history shifts on every emitted index.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ssig_pkg::PH_DONE;
         run_count_ff  <= '0;
         run_left_ff   <= '0;
         pair_half_ff  <= 1'b0;
         hist_one_ff   <= '0;
         hist_two_ff   <= '0;
         hist_three_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         run_count_ff <= run_count_in;
         run_left_ff  <= run_left_in;
         pair_half_ff <= pair_half_in;
         if (item.valid && emit) begin
            hist_three_ff <= cur_two;
            hist_two_ff   <= cur_one;
            hist_one_ff   <= index_val;
         end
      end
   end

   assign result.emit         = item.valid && emit;
   assign result.vertex_index = index_val;
   assign result.last         = last;

endmodule

`default_nettype wire

// File: hdl/ssig_out_stage.sv
// Result register of the generator: drives the response channel and tells
// the input stage when it has room. Depends on ssig_pkg and ssig_rsp_if.
`default_nettype none

module ssig_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ssig_pkg::result_type  result,
   ssig_rsp_if.source                 rsp_ch,
   output logic                       out_free
);

   logic                         valid_ff, valid_in;
   logic [ssig_pkg::INDEX_W-1:0] index_ff, index_in;
   logic                         last_ff, last_in;

   // Room exists when the register is empty or its beat leaves this cycle.
   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      index_in = index_ff;
      last_in  = last_ff;
      if (result.emit) begin
         valid_in = 1'b1;
         index_in = result.vertex_index;
         last_in  = result.last;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.vertex_index = index_ff;
   assign rsp_ch.last         = last_ff;

endmodule

`default_nettype wire
